### rtl/core/best_rational_approximation_defines.svh
// ----------------------------------------------------------------------------
// Best rational approximation: assertion macros
// Shared concurrent assertion forms for the checker of the block.
// ----------------------------------------------------------------------------
`ifndef BEST_RATIONAL_APPROXIMATION_DEFINES_SVH
`define BEST_RATIONAL_APPROXIMATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BRA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bra_pkg.sv
// ----------------------------------------------------------------------------
// Best rational approximation package
// Widths, reset value and sequencer interface types shared by the block.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned DENOM_BITS = 12;
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned NUM_BITS   = 28;

  localparam int unsigned WHOLE_BITS = TIME_BITS - FRAC_BITS;
  localparam int unsigned ERR_BITS   = FRAC_BITS + DENOM_BITS;
  localparam int unsigned DIST_BITS  = ERR_BITS + DENOM_BITS;

  localparam int unsigned MA_BASE    = (ERR_BITS > WHOLE_BITS) ? ERR_BITS : WHOLE_BITS;
  localparam int unsigned MA_BITS    = ((MA_BASE > NUM_BITS) ? MA_BASE : NUM_BITS) + 1;
  localparam int unsigned PROD_BITS  = MA_BITS + DENOM_BITS + 1;

  localparam int unsigned MAX_DENOM_RESET = 16;

  typedef struct packed {
    logic start;
    logic take;
  } seq_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_sts_t;

endpackage

### rtl/core/bra_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed operand times unsigned denominator, used by every sequencer step.
// ----------------------------------------------------------------------------
module bra_mul
  import bra_pkg::*;
(
  input  logic signed [MA_BITS-1:0]    a_i,
  input  logic        [DENOM_BITS-1:0] b_i,
  output logic signed [PROD_BITS-1:0]  p_o
);

  logic signed [DENOM_BITS:0] b_s;

  assign b_s = $signed({1'b0, b_i});
  assign p_o = a_i * b_s;

endmodule

### rtl/core/bra_seq.sv
// ----------------------------------------------------------------------------
// Mediant search sequencer
// Runs the search, the distance compare and the numerator fix-up on the
// shared multiplier, one step per cycle.
// ----------------------------------------------------------------------------
module bra_seq
  import bra_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  seq_ctl_t              ctl_i,
  output seq_sts_t              sts_o,
  input  logic [TIME_BITS-1:0]  beat_time_i,
  input  logic [DENOM_BITS-1:0] max_denom_i,
  output logic [NUM_BITS-1:0]   num_o,
  output logic [DENOM_BITS-1:0] den_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_ERR_B, ST_ERR_A, ST_DIST_B, ST_DIST_A, ST_NUMER, ST_DONE
  } state_e;

  state_e                  state_q;
  logic [FRAC_BITS-1:0]    frac_q;
  logic [WHOLE_BITS-1:0]   whole_q;
  logic [DENOM_BITS-1:0]   na_q, da_q, nb_q, db_q;
  logic [ERR_BITS-1:0]     eb_q, ea_q;
  logic [DIST_BITS-1:0]    distb_q;
  logic [DENOM_BITS-1:0]   nsel_q, dsel_q;
  logic [NUM_BITS-1:0]     num_q;

  logic [DENOM_BITS:0]     dsum;
  logic [DENOM_BITS-1:0]   dc, nc;
  logic [ERR_BITS-1:0]     nc_scaled, na_scaled, nb_scaled;
  logic signed [MA_BITS-1:0]   mul_a;
  logic [DENOM_BITS-1:0]       mul_b;
  logic signed [PROD_BITS-1:0] mul_p;
  logic [ERR_BITS-1:0]     prod_err;
  logic [DIST_BITS-1:0]    prod_dist;
  logic [NUM_BITS-1:0]     prod_num;
  logic                    go_on, lt, hit;

  assign dsum      = {1'b0, da_q} + {1'b0, db_q};
  assign dc        = dsum[DENOM_BITS-1:0];
  assign nc        = na_q + nb_q;
  assign nc_scaled = {nc, {FRAC_BITS{1'b0}}};
  assign na_scaled = {na_q, {FRAC_BITS{1'b0}}};
  assign nb_scaled = {nb_q, {FRAC_BITS{1'b0}}};

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = $signed({{(MA_BITS-FRAC_BITS){1'b0}}, frac_q});
    mul_b = dc;
    case (state_q)
      ST_ERR_B:  mul_b = db_q;
      ST_ERR_A:  mul_b = da_q;
      ST_DIST_B: begin
        mul_a = $signed({{(MA_BITS-ERR_BITS){1'b0}}, eb_q});
        mul_b = da_q;
      end
      ST_DIST_A: begin
        mul_a = $signed({{(MA_BITS-ERR_BITS){1'b0}}, ea_q});
        mul_b = db_q;
      end
      ST_NUMER: begin
        mul_a = $signed({{(MA_BITS-WHOLE_BITS){whole_q[WHOLE_BITS-1]}}, whole_q});
        mul_b = dsel_q;
      end
      default: ;
    endcase
  end

  bra_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  assign prod_err  = mul_p[ERR_BITS-1:0];
  assign prod_dist = mul_p[DIST_BITS-1:0];
  assign prod_num  = mul_p[NUM_BITS-1:0];

  assign go_on = (dsum <= {1'b0, max_denom_i});
  assign lt    = (prod_err < nc_scaled);
  // Lower bound unchanged: it can only equal the fraction when that is zero
  assign hit   = lt ? (frac_q == '0) : (prod_err == nc_scaled);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      frac_q  <= '0;
      whole_q <= '0;
      na_q    <= '0;
      da_q    <= '0;
      nb_q    <= '0;
      db_q    <= '0;
      eb_q    <= '0;
      ea_q    <= '0;
      distb_q <= '0;
      nsel_q  <= '0;
      dsel_q  <= '0;
      num_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (ctl_i.start) begin
            frac_q  <= beat_time_i[FRAC_BITS-1:0];
            whole_q <= beat_time_i[TIME_BITS-1:FRAC_BITS];
            na_q    <= '0;
            da_q    <= DENOM_BITS'(1);
            nb_q    <= DENOM_BITS'(1);
            db_q    <= DENOM_BITS'(1);
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (!go_on) begin
            state_q <= ST_ERR_B;
          end else begin
            if (lt) begin
              nb_q <= nc;
              db_q <= dc;
            end else begin
              na_q <= nc;
              da_q <= dc;
            end
            if (hit) begin
              state_q <= ST_ERR_B;
            end
          end
        end
        ST_ERR_B: begin
          eb_q    <= nb_scaled - prod_err;
          state_q <= ST_ERR_A;
        end
        ST_ERR_A: begin
          ea_q    <= prod_err - na_scaled;
          state_q <= ST_DIST_B;
        end
        ST_DIST_B: begin
          distb_q <= prod_dist;
          state_q <= ST_DIST_A;
        end
        ST_DIST_A: begin
          // Ties go to the lower bound
          if (distb_q < prod_dist) begin
            nsel_q <= nb_q;
            dsel_q <= db_q;
          end else begin
            nsel_q <= na_q;
            dsel_q <= da_q;
          end
          state_q <= ST_NUMER;
        end
        ST_NUMER: begin
          num_q   <= prod_num + {{(NUM_BITS-DENOM_BITS){1'b0}}, nsel_q};
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (ctl_i.take) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign sts_o.busy = (state_q != ST_IDLE);
  assign sts_o.done = (state_q == ST_DONE);
  assign num_o      = num_q;
  assign den_o      = dsel_q;

endmodule

### rtl/core/best_rational_approximation.sv
// ----------------------------------------------------------------------------
// Best rational approximation
// Nearest fraction with bounded denominator to a signed fixed-point time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat_time request, a
//   signed time with FRAC_BITS fraction bits. Output channel (out_valid_o /
//   out_stall_i) returns numerator and denominator of the nearest fraction
//   whose denominator does not exceed the larger of max_denominator and one, floor included.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes
//   max_denominator; write it only while no request is in flight.
//   Sequence: the search loop takes mediant steps until the denominator
//   limit would be passed or an exact hit is found; then come the two
//   errors, the two distances with the choice of bound, the numerator and
//   the hand-over to out_valid_o. The shared multiplier is used once per step.
//   Throughput: one request at a time; in_stall_o stays high from accept
//   until the result has moved into the output register.
//   Reset clears the sequencer and the output valid, and loads
//   max_denominator with 16.
//   A stalled receiver holds the result in the output register; a further
//   request may run meanwhile and then waits in the sequencer.
// ----------------------------------------------------------------------------
module best_rational_approximation
  import bra_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [DENOM_BITS-1:0]        cfg_data_i,
  // Request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [TIME_BITS-1:0]  beat_time_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [NUM_BITS-1:0]   numerator_o,
  output logic [DENOM_BITS-1:0]        denominator_o
);

  logic [DENOM_BITS-1:0] max_denom_q;
  logic                  out_valid_q;
  logic [NUM_BITS-1:0]   num_q;
  logic [DENOM_BITS-1:0] den_q;

  seq_ctl_t              seq_ctl;
  seq_sts_t              seq_sts;
  logic [NUM_BITS-1:0]   seq_num;
  logic [DENOM_BITS-1:0] seq_den;
  logic                  load;

  // Configuration is always taken; the sequencer is idle by contract
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_denom_q <= DENOM_BITS'(MAX_DENOM_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_denom_q <= cfg_data_i;
    end
  end

  // Stall requests while the sequencer holds one
  assign in_stall_o    = seq_sts.busy;
  assign seq_ctl.start = in_valid_i && !seq_sts.busy;

  // Move the finished result into the output register when it is free
  assign load         = seq_sts.done && (!out_valid_q || !out_stall_i);
  assign seq_ctl.take = load;

  bra_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (seq_ctl),
    .sts_o       (seq_sts),
    .beat_time_i (beat_time_i),
    .max_denom_i (max_denom_q),
    .num_o       (seq_num),
    .den_o       (seq_den)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      num_q       <= '0;
      den_q       <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      num_q       <= seq_num;
      den_q       <= seq_den;
    end else if (out_valid_q && !out_stall_i) begin
      // Drop the result once taken
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign numerator_o   = $signed(num_q);
  assign denominator_o = den_q;

endmodule

### rtl/core/bra_checker.sv
// ----------------------------------------------------------------------------
// Best rational approximation checker
// Port-level assertions on requests and results, bound to the top.
// ----------------------------------------------------------------------------
`include "best_rational_approximation_defines.svh"

module bra_checker
  import bra_pkg::*;
(
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [NUM_BITS-1:0]   numerator_o,
  input logic [DENOM_BITS-1:0]        denominator_o
);

  logic in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  `BRA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_accept, in_stall_o, "request accepted but block not busy")
  `BRA_ASSERT_IMPL(a_denom_nonzero, clk_i, rst_ni, out_valid_o, denominator_o != '0, "result with zero denominator")
  `BRA_ASSERT_IMPL(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result without preceding work")
  `BRA_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(numerator_o) && $stable(denominator_o), "stalled result changed")

endmodule

bind best_rational_approximation bra_checker u_bra_checker (.*);

### test/tb_best_rational_approximation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Best rational approximation testbench
// Drives beat time requests through the block under random idling and
// back-pressure, predicts each nearest fraction with an integer Stern-Brocot
// search of its own and compares numerator and denominator in order.
// ----------------------------------------------------------------------------
module tb_best_rational_approximation;
  import bra_pkg::*;

  localparam int unsigned HALF_PERIOD     = 6;
  localparam int unsigned RESET_CYCLES    = 7;
  localparam int unsigned IDLE_PERCENT    = 19;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  // Worst case is far below this: only about a dozen requests run at the
  // widest denominator, the rest at smaller limits.
  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int unsigned MAX_DENOM_TOP   = (1 << DENOM_BITS) - 1;

  // One expected result, tagged with the request that caused it
  typedef struct {
    logic signed [TIME_BITS-1:0] onset;
    logic signed [NUM_BITS-1:0]  numerator;
    logic [DENOM_BITS-1:0]       denominator;
  } fraction_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_valid_i   = 1'b0;
  logic                        cfg_ready_o;
  logic [DENOM_BITS-1:0]       cfg_data_i    = '0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_stall_o;
  logic signed [TIME_BITS-1:0] beat_time_i   = '0;
  logic                        out_valid_o;
  logic                        out_stall_i   = 1'b0;
  logic signed [NUM_BITS-1:0]  numerator_o;
  logic [DENOM_BITS-1:0]       denominator_o;

  fraction_t             pending_fractions [$];
  logic [DENOM_BITS-1:0] max_denom_model = DENOM_BITS'(MAX_DENOM_RESET);
  int unsigned           mismatch_count  = 0;
  int unsigned           cycle_count     = 0;
  logic                  calm            = 1'b0;  // suppress idling on both sides
  logic                  rx_hold         = 1'b0;  // long receiver hold-off
  event                  hold_off_ev;

  best_rational_approximation u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .beat_time_i   (beat_time_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .numerator_o   (numerator_o),
    .denominator_o (denominator_o)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: nearest fraction with bounded denominator. Split the time into
  // floor and fraction, walk the mediants between 0/1 and 1/1 while the two
  // bound denominators sum to at most the limit, stop on an exact hit, take
  // the closer bound (lower one on a tie) and add the floor back in.
  // --------------------------------------------------------------------------
  function automatic fraction_t nearest_fraction(logic signed [TIME_BITS-1:0] onset,
                                                 logic [DENOM_BITS-1:0] limit);
    longint unsigned scale, frac;
    longint unsigned lo_n, lo_d, hi_n, hi_d, mid_n, mid_d;
    longint unsigned err_hi, err_lo, pick_n, pick_d;
    longint          whole, num;
    fraction_t       res;
    scale = 64'd1 << FRAC_BITS;
    frac  = longint'(onset[FRAC_BITS-1:0]);
    whole = longint'(onset >>> FRAC_BITS);
    lo_n  = 0;
    lo_d  = 1;
    hi_n  = 1;
    hi_d  = 1;
    while (lo_d + hi_d <= limit) begin
      mid_n = lo_n + hi_n;
      mid_d = lo_d + hi_d;
      if (frac * mid_d < mid_n * scale) begin
        hi_n = mid_n;
        hi_d = mid_d;
      end else begin
        lo_n = mid_n;
        lo_d = mid_d;
      end
      if (frac * lo_d == lo_n * scale) break;
    end
    // lo_n/lo_d <= fraction < hi_n/hi_d, so both distances are non-negative
    err_hi = (hi_n * scale - frac * hi_d) * lo_d;
    err_lo = (frac * lo_d - lo_n * scale) * hi_d;
    if (err_hi < err_lo) begin
      pick_n = hi_n;
      pick_d = hi_d;
    end else begin
      pick_n = lo_n;
      pick_d = lo_d;
    end
    num             = longint'(pick_n) + whole * longint'(pick_d);
    res.onset       = onset;
    res.numerator   = num[NUM_BITS-1:0];
    res.denominator = pick_d[DENOM_BITS-1:0];
    return res;
  endfunction

  // Random time, weighted towards small floors, dyadic fractions, fractions
  // near an integer, fractions near a simple ratio and zero fractions.
  function automatic logic [TIME_BITS-1:0] random_onset();
    logic [TIME_BITS-1:0] v;
    logic [FRAC_BITS-1:0] f;
    int unsigned          d;
    v = $urandom;
    case ($urandom_range(9))
      4, 5: begin
        v[TIME_BITS-1:FRAC_BITS+3] = {(TIME_BITS-FRAC_BITS-3){v[FRAC_BITS+3]}};
      end
      6: begin
        f = FRAC_BITS'($urandom);
        v[FRAC_BITS-1:0] = f << $urandom_range(FRAC_BITS - 1);
      end
      7: begin
        v[FRAC_BITS-1:0] = v[0] ? FRAC_BITS'($urandom_range(3))
                                : FRAC_BITS'((1 << FRAC_BITS) - 1 - $urandom_range(3));
      end
      8: begin
        d = $urandom_range(64, 2);
        v[FRAC_BITS-1:0] = FRAC_BITS'(($urandom_range(d - 1, 1) << FRAC_BITS) / d
                                      + $urandom_range(2) - 1);
      end
      9: begin
        v[FRAC_BITS-1:0] = '0;
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: stall at random, hold off completely while rx_hold is set
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_stall_i <= rx_hold || (!calm && ($urandom_range(99) < IDLE_PERCENT));
  end

  // Count out the long hold-off in its own process
  always begin
    @(hold_off_ev);
    rx_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Result check: compare each accepted result with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    fraction_t exp_frac;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_fractions.size() == 0) begin
        $display("%0t: result %0d/%0d with no request outstanding",
                 $time, numerator_o, denominator_o);
        mismatch_count <= mismatch_count + 1;
      end else begin
        exp_frac = pending_fractions.pop_front();
        if (numerator_o !== exp_frac.numerator) begin
          $display("%0t: numerator for onset %h: expected %0d, actual %0d",
                   $time, exp_frac.onset, exp_frac.numerator, numerator_o);
          mismatch_count <= mismatch_count + 1;
        end
        if (denominator_o !== exp_frac.denominator) begin
          $display("%0t: denominator for onset %h: expected %0d, actual %0d",
                   $time, exp_frac.onset, exp_frac.denominator, denominator_o);
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one request, wait for acceptance, record its expected fraction and
  // maybe idle afterwards. Valid stays high when the next request follows.
  task automatic send_onset(input logic [TIME_BITS-1:0] onset);
    in_valid_i  <= 1'b1;
    beat_time_i <= onset;
    do @(posedge clk_i); while (in_stall_o);
    pending_fractions.push_back(nearest_fraction(onset, max_denom_model));
    if (!calm && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_valid_i  <= 1'b0;
      beat_time_i <= $urandom;
      do @(posedge clk_i); while (!calm && ($urandom_range(99) < IDLE_PERCENT));
    end
  endtask

  task automatic wait_for_results();
    while (pending_fractions.size() != 0) @(posedge clk_i);
  endtask

  // Drain, let the search settle, then write the denominator limit
  task automatic write_max_denominator(input logic [DENOM_BITS-1:0] value);
    in_valid_i <= 1'b0;
    wait_for_results();
    repeat (int'(max_denom_model) + 8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i     <= 1'b0;
    max_denom_model  = value;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, exact hits, ties and zero fractions at the reset limit
  task automatic test_directed_default();
    send_onset(32'h0000_0000);   // zero
    send_onset(32'h0000_0001);   // smallest fraction
    send_onset(32'h0000_FFFF);   // largest fraction
    send_onset(32'h7FFF_FFFF);   // most positive time
    send_onset(32'h8000_0000);   // most negative time, zero fraction
    send_onset(32'hFFFF_FFFF);   // just below zero
    send_onset(32'h0001_0000);   // one, zero fraction
    send_onset(32'h0000_6000);   // 3/8, exact hit mid-search
    send_onset(32'h0000_1000);   // 1/16, exact hit at the limit
    send_onset(32'h0000_0800);   // 1/32, tie between 0/1 and 1/16
    send_onset(32'h0003_243F);   // near pi
    send_onset(32'hFFFC_DBC1);   // near minus pi
    send_onset(32'hAAAA_AAAA);
    send_onset(32'h5555_5555);
  endtask

  // Limits of one and zero: no search, closer of 0/1 and 1/1, tie to 0/1
  task automatic test_max_below_two();
    write_max_denominator(DENOM_BITS'(1));
    send_onset(32'h0000_8000);   // tie
    send_onset(32'h0000_8001);
    send_onset(32'hFFFF_7FFF);
    send_onset(32'h0002_0000);   // zero fraction
    write_max_denominator('0);
    send_onset(32'h0000_8000);   // tie
    send_onset(32'h8000_C000);
    send_onset(32'h7FFF_0000);   // zero fraction
  endtask

  // Widest limit: the deepest searches
  task automatic test_max_top();
    write_max_denominator(DENOM_BITS'(MAX_DENOM_TOP));
    send_onset(32'h0000_0001);
    send_onset(32'h7FFF_FFFF);
    send_onset(32'h8000_0001);
    send_onset(32'hFFFF_5555);
  endtask

  // Random requests over several limits, mostly small ones
  task automatic test_random_limits();
    int unsigned count;
    for (int phase = 0; phase < 7; phase++) begin
      count = 14;
      case (phase)
        0: write_max_denominator(DENOM_BITS'(2));
        1: write_max_denominator(DENOM_BITS'($urandom_range(20, 3)));
        2: write_max_denominator(DENOM_BITS'($urandom_range(100, 21)));
        3: begin
          write_max_denominator(DENOM_BITS'(MAX_DENOM_TOP));
          count = 8;
        end
        4: begin
          write_max_denominator(DENOM_BITS'($urandom_range(600, 101)));
          count = 12;
        end
        5: write_max_denominator(DENOM_BITS'($urandom_range(1)));
        default: write_max_denominator(DENOM_BITS'($urandom_range(40, 2)));
      endcase
      repeat (count) send_onset(random_onset());
    end
  endtask

  // No idling on either side for a while
  task automatic test_back_to_back();
    write_max_denominator(DENOM_BITS'($urandom_range(12, 2)));
    calm <= 1'b1;
    repeat (24) send_onset(random_onset());
    calm <= 1'b0;
  endtask

  // Hold the receiver off so the block fills and stalls its input, then
  // pause the sender until every result has come back
  task automatic test_back_pressure();
    write_max_denominator(DENOM_BITS'(8));
    -> hold_off_ev;
    repeat (6) send_onset(random_onset());
    in_valid_i <= 1'b0;
    wait_for_results();
    repeat (4) send_onset(random_onset());
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_default();
    test_max_below_two();
    test_max_top();
    test_random_limits();
    test_back_to_back();
    test_back_pressure();

    // Drain, then keep clocking before the verdict to catch stray results
    in_valid_i <= 1'b0;
    wait_for_results();
    repeat (int'(max_denom_model) + 16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
